// ----- rtl/pii_scan_pkg.sv -----
// ============================================================================
// pii_scan_pkg
// Shared types, constants and byte classifiers for the personal-data scanner.
// ============================================================================
`default_nettype none

package pii_scan_pkg;

  localparam int DIGIT_RUN_LIMIT_DEF = 10;
  localparam int HIST_DEPTH          = 10;
  localparam int DOMAIN_CHECK_LEN    = 11;
  localparam int NUM_NAMES           = 3;
  localparam int NAME_W              = 8 * DOMAIN_CHECK_LEN;
  localparam int DOM_LEN_W           = $clog2(DOMAIN_CHECK_LEN + 1);

  localparam logic [7:0] CHAR_AT   = 8'h40;
  localparam logic [7:0] CHAR_DASH = 8'h2D;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [7:0] CHAR_USCR = 8'h5F;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_DIGIT = 2'd1,
    CLS_DASH  = 2'd2
  } byte_class_t;

  // classes of the ten bytes ahead of a digit, newest first
  localparam byte_class_t SSN_SHAPE [HIST_DEPTH] = '{
    CLS_DIGIT, CLS_DIGIT, CLS_DIGIT, CLS_DASH, CLS_DIGIT,
    CLS_DIGIT, CLS_DASH, CLS_DIGIT, CLS_DIGIT, CLS_DIGIT
  };

  localparam logic [NAME_W-1:0] ALLOWED_NAMES [NUM_NAMES] = '{
    "example.com", "example.org", "example.net"
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_domain_byte(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CHAR_DOT) || (c == CHAR_DASH) || (c == CHAR_USCR);
  endfunction

  function automatic byte_class_t classify(input logic [7:0] c);
    byte_class_t cls;
    if (is_digit(c)) begin
      cls = CLS_DIGIT;
    end else if (c == CHAR_DASH) begin
      cls = CLS_DASH;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

  // character at position pos of an allowed name, first character at 0
  function automatic logic [7:0] name_char(input logic [NAME_W-1:0] name,
                                           input logic [DOM_LEN_W-1:0] pos);
    logic [7:0] ch;
    ch = '0;
    for (int i = 0; i < DOMAIN_CHECK_LEN; i++) begin
      if (pos == DOM_LEN_W'(i)) begin
        ch = name[8*(DOMAIN_CHECK_LEN-1-i) +: 8];
      end
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pii_pattern_scanner.sv -----
// ============================================================================
// pii_pattern_scanner
// Streaming scanner that refuses text holding ID numbers, long digit runs or
// mail addresses outside the example domains.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall): one text byte per item, with
//   in_last_byte high on the final byte of a stream.
//   Result channel (out_valid / out_stall): one item per stream, out_refused,
//   issued for the final byte; no result for other bytes.
//   Throughput: one byte per cycle while in_stall stays low, set by the single
//   update pass between the input register and the scan state.
//   Result path: the final byte goes through the input register, then the
//   result register, which raises out_valid.
//   Stall: while out_stall holds a pending verdict, ordinary bytes keep
//   flowing; a further final byte waits in the input register and in_stall
//   rises until the result register frees.
//   Reset: rst_n (synchronous, active low) empties both registers and clears
//   the scan state; the state clears again after every final byte.
// ============================================================================
`default_nettype none

module pii_pattern_scanner
  import pii_scan_pkg::*;
#(
  parameter int DIGIT_RUN_LIMIT = DIGIT_RUN_LIMIT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_refused
);

  localparam int RunW = $clog2(DIGIT_RUN_LIMIT + 1);

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // scan state
  byte_class_t                class_hist_r [HIST_DEPTH];
  logic [RunW-1:0]            run_cnt_r;
  logic                       in_domain_r;
  logic [DOM_LEN_W-1:0]       domain_len_r;
  logic [NUM_NAMES-1:0]       prefix_match_r;
  logic                       violation_r;

  // result register
  logic out_valid_r;
  logic out_refused_r;

  logic                 proceed;
  byte_class_t          cls;
  logic                 ssn_hit;
  logic [RunW-1:0]      run_cnt_nxt;
  logic                 in_domain_nxt;
  logic [DOM_LEN_W-1:0] domain_len_nxt;
  logic [NUM_NAMES-1:0] prefix_match_nxt;
  logic                 violation_nxt;
  logic                 verdict;

  assign proceed  = in_valid_r && (!in_last_r || !out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !proceed;

  assign out_valid   = out_valid_r;
  assign out_refused = out_refused_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
  end

  always_comb begin
    cls     = classify(in_byte_r);
    ssn_hit = (cls == CLS_DIGIT);
    for (int i = 0; i < HIST_DEPTH; i++) begin
      if (class_hist_r[i] != SSN_SHAPE[i]) begin
        ssn_hit = 1'b0;
      end
    end

    run_cnt_nxt   = '0;
    violation_nxt = violation_r | ssn_hit;
    if (cls == CLS_DIGIT) begin
      run_cnt_nxt = (run_cnt_r < RunW'(DIGIT_RUN_LIMIT)) ? run_cnt_r + 1'b1 : run_cnt_r;
      if (run_cnt_nxt >= RunW'(DIGIT_RUN_LIMIT)) begin
        violation_nxt = 1'b1;
      end
    end

    in_domain_nxt    = in_domain_r;
    domain_len_nxt   = domain_len_r;
    prefix_match_nxt = prefix_match_r;
    if (in_domain_r) begin
      if (is_domain_byte(in_byte_r)) begin
        for (int k = 0; k < NUM_NAMES; k++) begin
          if (name_char(ALLOWED_NAMES[k], domain_len_r) != in_byte_r) begin
            prefix_match_nxt[k] = 1'b0;
          end
        end
        domain_len_nxt = domain_len_r + 1'b1;
        if (prefix_match_nxt == '0) begin
          violation_nxt = 1'b1;
          in_domain_nxt = 1'b0;
        end else if (domain_len_nxt == DOM_LEN_W'(DOMAIN_CHECK_LEN)) begin
          in_domain_nxt = 1'b0;
        end
      end else begin
        if (domain_len_r != '0) begin
          violation_nxt = 1'b1;
        end
        in_domain_nxt = 1'b0;
      end
    end
    if (in_byte_r == CHAR_AT) begin
      in_domain_nxt    = 1'b1;
      domain_len_nxt   = '0;
      prefix_match_nxt = '1;
    end

    // an open, nonempty domain at the end of the stream counts as a violation
    verdict = violation_nxt | (in_domain_nxt && (domain_len_nxt != '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (proceed && in_last_r)) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        class_hist_r[i] <= CLS_OTHER;
      end
      run_cnt_r      <= '0;
      in_domain_r    <= 1'b0;
      domain_len_r   <= '0;
      prefix_match_r <= '1;
      violation_r    <= 1'b0;
    end else if (proceed) begin
      class_hist_r[0] <= cls;
      for (int i = 1; i < HIST_DEPTH; i++) begin
        class_hist_r[i] <= class_hist_r[i-1];
      end
      run_cnt_r      <= run_cnt_nxt;
      in_domain_r    <= in_domain_nxt;
      domain_len_r   <= domain_len_nxt;
      prefix_match_r <= prefix_match_nxt;
      violation_r    <= violation_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proceed && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && in_last_r) begin
      out_refused_r <= verdict;
    end
  end

  // checks
  a_domain_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_domain_r |-> (domain_len_r < DOM_LEN_W'(DOMAIN_CHECK_LEN)))
    else $error("domain length past check window");

  a_domain_live_match: assert property (@(posedge clk) disable iff (!rst_n)
    in_domain_r |-> (prefix_match_r != '0))
    else $error("open domain with no allowed name left");

  a_run_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    run_cnt_r <= RunW'(DIGIT_RUN_LIMIT))
    else $error("digit run counter past limit");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (proceed && in_last_r) |=> (!violation_r && !in_domain_r && (run_cnt_r == '0)
                                && out_valid_r))
    else $error("state not cleared or verdict missing after final item");

endmodule

`default_nettype wire
